// File: src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition that must never be true at a clock edge.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `ASSERT_PROP(lbl, clk, rstn, !(cond), msg)

`endif

// File: src/ppp_pkg.sv
package ppp_pkg;

  // Operation codes of an input word.
  localparam logic [1:0] OP_PROJECT = 2'd0;
  localparam logic [1:0] OP_FILL    = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  // Result status codes.
  localparam logic [2:0] STAT_DRAWN  = 3'd0;
  localparam logic [2:0] STAT_BEHIND = 3'd1;
  localparam logic [2:0] STAT_OFF    = 3'd2;
  localparam logic [2:0] STAT_FILLED = 3'd3;
  localparam logic [2:0] STAT_READ   = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_ROLL  = 3'd0;
  localparam logic [2:0] REG_PITCH = 3'd1;
  localparam logic [2:0] REG_CAMX  = 3'd2;
  localparam logic [2:0] REG_CAMY  = 3'd3;
  localparam logic [2:0] REG_CAMZ  = 3'd4;
  localparam logic [2:0] REG_FOCAL = 3'd5;
  localparam logic [2:0] REG_PP    = 3'd6;

  // Datapath widths.
  localparam int unsigned OpAW   = 40;  // multiplier operand a
  localparam int unsigned OpBW   = 25;  // multiplier operand b
  localparam int unsigned AccW   = 64;  // accumulator
  localparam int unsigned DivNW  = 64;  // dividend and quotient
  localparam int unsigned DivDW  = 37;  // divisor (positive depth)

  // Command word to the multiply-accumulate unit.
  typedef struct packed {
    logic                   valid;
    logic                   clear;
    logic signed [OpAW-1:0] a;
    logic signed [OpBW-1:0] b;
  } mac_cmd_t;

  typedef enum logic [1:0] {
    MAC_IDLE,
    MAC_LO,
    MAC_HI,
    MAC_ACC
  } mac_phase_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_FIX
  } div_phase_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FILL,
    S_READ,
    S_RDONE,
    S_MAC,
    S_MACW,
    S_DIVU,
    S_DIVUW,
    S_DIVV,
    S_DIVVW,
    S_PLACE,
    S_WRITE
  } ctl_state_e;

  // Product sequence of one projection.
  typedef enum logic [3:0] {
    STEP_SASB,
    STEP_SACB,
    STEP_CASB,
    STEP_CACB,
    STEP_DXCB,
    STEP_DZSB,
    STEP_DXR10,
    STEP_DYCA,
    STEP_DZR12,
    STEP_DXR20,
    STEP_DYSA,
    STEP_DZR22,
    STEP_XCFU,
    STEP_YCFV
  } step_e;

endpackage

// File: src/ppp_ram.sv
module ppp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port, registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/ppp_mac.sv
module ppp_mac import ppp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mac_cmd_t               cmd_i,
  output logic                   done_o,
  output logic signed [AccW-1:0] acc_o
);

  localparam int unsigned LoW   = 20;
  localparam int unsigned ProdW = LoW + 1 + OpBW;

  mac_phase_e              phase_q, phase_d;
  logic                    done_q;
  logic                    clr_q;
  logic signed [OpAW-1:0]  a_q;
  logic signed [OpBW-1:0]  b_q;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic signed [AccW-1:0]  acc_q;
  logic signed [AccW-1:0]  prod_ext;

  // Phase sequence: low partial product, high partial product, final add.
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      MAC_IDLE: if (cmd_i.valid) phase_d = MAC_LO;
      MAC_LO:   phase_d = MAC_HI;
      MAC_HI:   phase_d = MAC_ACC;
      MAC_ACC:  phase_d = MAC_IDLE;
      default:  phase_d = MAC_IDLE;
    endcase
  end

  // Partial product of the operand half that the phase selects.
  always_comb begin
    if (phase_q == MAC_LO) begin
      prod_d = $signed({1'b0, a_q[LoW-1:0]}) * b_q;
    end else begin
      prod_d = $signed(a_q[OpAW-1:LoW]) * b_q;
    end
    prod_ext = {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= MAC_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= (phase_q == MAC_ACC);
    end
  end

  // Operand capture and accumulation.
  always_ff @(posedge clk_i) begin
    if (phase_q == MAC_IDLE && cmd_i.valid) begin
      a_q   <= cmd_i.a;
      b_q   <= cmd_i.b;
      clr_q <= cmd_i.clear;
    end
    prod_q <= prod_d;
    unique case (phase_q)
      MAC_LO:  if (clr_q) acc_q <= '0;
      MAC_HI:  acc_q <= acc_q + prod_ext;
      MAC_ACC: acc_q <= acc_q + (prod_ext <<< LoW);
      default: acc_q <= acc_q;
    endcase
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

// File: src/ppp_div.sv
module ppp_div import ppp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DivNW-1:0] dividend_i,
  input  logic [DivDW-1:0]        divisor_i,
  output logic                    done_o,
  output logic signed [DivNW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(DivNW);

  div_phase_e              phase_q, phase_d;
  logic                    done_q;
  logic [CntW-1:0]         cnt_q;
  logic                    neg_q;
  logic [DivNW-1:0]        num_q;
  logic [DivDW-1:0]        den_q;
  logic [DivDW-1:0]        rem_q;
  logic [DivDW:0]          rem_sh;
  logic                    qbit;
  logic [DivNW-1:0]        mag_up;
  logic signed [DivNW-1:0] quot_q;

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      DIV_IDLE: if (start_i) phase_d = DIV_RUN;
      DIV_RUN:  if (cnt_q == CntW'(DivNW - 1)) phase_d = DIV_FIX;
      DIV_FIX:  phase_d = DIV_IDLE;
      default:  phase_d = DIV_IDLE;
    endcase
  end

  // One restoring step per cycle; quotient bits shift in behind the dividend.
  always_comb begin
    rem_sh = {rem_q, num_q[DivNW-1]};
    qbit   = (rem_sh >= {1'b0, den_q});
    mag_up = num_q + DivNW'(rem_q != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= DIV_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= (phase_q == DIV_FIX);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (phase_q)
      DIV_IDLE: begin
        if (start_i) begin
          neg_q <= dividend_i[DivNW-1];
          num_q <= dividend_i[DivNW-1] ? DivNW'(-dividend_i) : DivNW'(dividend_i);
          den_q <= divisor_i;
          rem_q <= '0;
          cnt_q <= '0;
        end
      end
      DIV_RUN: begin
        rem_q <= qbit ? DivDW'(rem_sh - {1'b0, den_q}) : DivDW'(rem_sh);
        num_q <= {num_q[DivNW-2:0], qbit};
        cnt_q <= cnt_q + 1'b1;
      end
      DIV_FIX: begin
        // Floor toward minus infinity for a negative dividend.
        quot_q <= neg_q ? $signed(-mag_up) : $signed(num_q);
      end
      default: cnt_q <= cnt_q;
    endcase
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: src/point_projection_plotter.sv
// Point projection plotter.
// Command channel: an input word is taken on a rising edge with start high and busy
// low. opcode selects project point, fill frame, read pixel, or none. Every word
// gives exactly one result, shown for one cycle with result_valid_o high; the
// receiver takes it at that edge and cannot hold it off.
// Configuration: APB-style port, one 64-bit register every 8 bytes, pready always
// high. The user writes only while the block is idle, not enforced by the block.
// Projection: 14 products on one shared multiply-accumulate unit (two partial
// products per product), then two divisions by depth on one iterative divider
// (64 quotient bits, then a sign fix), then placement and, for a point on the
// frame, the frame store write. A point behind the camera ends after 12 products.
// A read goes through the frame store's registered port. A fill sweeps the frame
// store, one word per cycle. busy stays high for the whole operation; words go
// one at a time.
// Reset: a clearing pass writes zero to every frame store word, one a cycle; busy
// is high meanwhile and configuration writes are still taken.
`include "assert_macros.svh"

module point_projection_plotter import ppp_pkg::*; #(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] point_x_i,
  input  logic [31:0] point_y_i,
  input  logic [31:0] point_z_i,
  input  logic [31:0] colour_i,
  input  logic [15:0] read_index_i,
  output logic        result_valid_o,
  output logic [2:0]  status_o,
  output logic [7:0]  pixel_x_o,
  output logic [7:0]  pixel_y_o,
  output logic [31:0] read_colour_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int PixelCount = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW         = (PixelCount > 1) ? $clog2(PixelCount) : 1;
  localparam int ColW       = 53;

  // Configuration registers.
  logic [31:0] roll_q, pitch_q, campx_q, campy_q, campz_q, pp_q;
  logic [47:0] focal_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_q  <= 32'h4000_0000;
      pitch_q <= 32'h4000_0000;
      campx_q <= '0;
      campy_q <= '0;
      campz_q <= '0;
      focal_q <= 48'h001000_001000;
      pp_q    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ROLL:  roll_q  <= pwdata[31:0];
        REG_PITCH: pitch_q <= pwdata[31:0];
        REG_CAMX:  campx_q <= pwdata[31:0];
        REG_CAMY:  campy_q <= pwdata[31:0];
        REG_CAMZ:  campz_q <= pwdata[31:0];
        REG_FOCAL: focal_q <= pwdata[47:0];
        REG_PP:    pp_q    <= pwdata[31:0];
        default:   ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_idx)
      REG_ROLL:  prdata = {32'b0, roll_q};
      REG_PITCH: prdata = {32'b0, pitch_q};
      REG_CAMX:  prdata = {32'b0, campx_q};
      REG_CAMY:  prdata = {32'b0, campy_q};
      REG_CAMZ:  prdata = {32'b0, campz_q};
      REG_FOCAL: prdata = {16'b0, focal_q};
      REG_PP:    prdata = {32'b0, pp_q};
      default:   prdata = '0;
    endcase
  end

  // Trig terms and focal fields, sign- or zero-extended to operand b; principal point fields.
  logic signed [OpBW-1:0] ca, sa, cb, sb, nsb, fu, fv;
  logic [15:0]            du, dv;

  assign ca  = OpBW'($signed(roll_q[31:16]));
  assign sa  = OpBW'($signed(roll_q[15:0]));
  assign cb  = OpBW'($signed(pitch_q[31:16]));
  assign sb  = OpBW'($signed(pitch_q[15:0]));
  assign nsb = -sb;
  assign fu  = $signed({1'b0, focal_q[47:24]});
  assign fv  = $signed({1'b0, focal_q[23:0]});
  assign du  = pp_q[31:16];
  assign dv  = pp_q[15:0];

  // Control and datapath state.
  ctl_state_e state_q, state_d;
  step_e      step_q;
  logic [AW-1:0] ptr_q;

  logic [31:0]            colour_q;
  logic [AW-1:0]          idx_q;
  logic                   rd_ok_q;
  logic signed [OpAW-1:0] dx_q, dy_q, dz_q;
  logic signed [17:0]     r10_q, r12_q, r20_q, r22_q;
  logic signed [OpAW-1:0] xc_q, yc_q, zc_q;
  logic signed [AccW-1:0] nu_q, nv_q;
  logic signed [64:0]     u_q, v_q;
  logic [AW-1:0]          waddr_q;

  // Result registers.
  logic        res_valid_q, res_valid_d;
  logic [2:0]  res_status_q, res_status_d;
  logic [7:0]  res_px_q, res_px_d, res_py_q, res_py_d;
  logic [31:0] res_col_q, res_col_d;

  // Sub-unit signals.
  mac_cmd_t               mac_cmd;
  logic                   mac_done;
  logic signed [AccW-1:0] mac_acc;
  logic signed [AccW-1:0] acc_sh;
  logic                   zc_le0;
  logic                   div_start;
  logic signed [DivNW-1:0] div_num;
  logic                   div_done;
  logic signed [DivNW-1:0] div_quot;
  logic                   ram_we;
  logic [AW-1:0]          ram_addr;
  logic [31:0]            ram_wdata, ram_rdata;

  logic                   take;
  logic                   ptr_last;
  logic [ColW-1:0]        col_full, row_full;
  logic                   off_frame;
  logic [23:0]            lin_addr;

  assign take     = start && (state_q == S_IDLE);
  assign busy     = (state_q != S_IDLE);
  assign ptr_last = (ptr_q == AW'(PixelCount - 1));
  assign acc_sh   = mac_acc >>> 14;
  assign zc_le0   = acc_sh[AccW-1] || (acc_sh == '0);
  assign col_full = u_q[64:12];
  assign row_full = v_q[64:12];
  assign off_frame = u_q[64] || v_q[64] || (col_full >= ColW'(FRAME_WIDTH))
                   || (row_full >= ColW'(FRAME_HEIGHT));
  assign lin_addr = 24'(row_full[11:0]) * 24'(FRAME_WIDTH) + 24'(col_full[11:0]);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (ptr_last) state_d = S_IDLE;
      S_IDLE: begin
        if (take) begin
          unique case (opcode_i)
            OP_PROJECT: state_d = S_MAC;
            OP_FILL:    state_d = S_FILL;
            OP_READ:    state_d = S_READ;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_FILL:  if (ptr_last) state_d = S_IDLE;
      S_READ:  state_d = S_RDONE;
      S_RDONE: state_d = S_IDLE;
      S_MAC:   state_d = S_MACW;
      S_MACW: begin
        if (mac_done) begin
          priority if (step_q == STEP_YCFV) state_d = S_DIVU;
          else if (step_q == STEP_DZR22 && zc_le0) state_d = S_IDLE;
          else state_d = S_MAC;
        end
      end
      S_DIVU:  state_d = S_DIVUW;
      S_DIVUW: if (div_done) state_d = S_DIVV;
      S_DIVV:  state_d = S_DIVVW;
      S_DIVVW: if (div_done) state_d = S_PLACE;
      S_PLACE: state_d = off_frame ? S_IDLE : S_WRITE;
      S_WRITE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs: frame store port, unit commands and the next result word.
  always_comb begin
    ram_we       = 1'b0;
    ram_addr     = ptr_q;
    ram_wdata    = '0;
    mac_cmd      = '0;
    div_start    = 1'b0;
    div_num      = nu_q;
    res_valid_d  = 1'b0;
    res_status_d = STAT_DRAWN;
    res_px_d     = '0;
    res_py_d     = '0;
    res_col_d    = '0;
    unique case (state_q)
      S_CLEAR: ram_we = 1'b1;
      S_IDLE: begin
        if (take && opcode_i == OP_NONE) begin
          res_valid_d  = 1'b1;
          res_status_d = STAT_OFF;
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = colour_q;
        if (ptr_last) begin
          res_valid_d  = 1'b1;
          res_status_d = STAT_FILLED;
        end
      end
      S_READ: ram_addr = idx_q;
      S_RDONE: begin
        res_valid_d  = 1'b1;
        res_status_d = STAT_READ;
        res_col_d    = rd_ok_q ? ram_rdata : '0;
      end
      S_MAC: begin
        mac_cmd.valid = 1'b1;
        unique case (step_q)
          STEP_SASB:  begin mac_cmd.a = OpAW'(sa);   mac_cmd.b = sb;  end
          STEP_SACB:  begin mac_cmd.a = OpAW'(sa);   mac_cmd.b = cb;  end
          STEP_CASB:  begin mac_cmd.a = OpAW'(ca);   mac_cmd.b = sb;  end
          STEP_CACB:  begin mac_cmd.a = OpAW'(ca);   mac_cmd.b = cb;  end
          STEP_DXCB:  begin mac_cmd.a = dx_q;        mac_cmd.b = cb;  end
          STEP_DZSB:  begin mac_cmd.a = dz_q;        mac_cmd.b = nsb; end
          STEP_DXR10: begin mac_cmd.a = dx_q; mac_cmd.b = OpBW'(r10_q); end
          STEP_DYCA:  begin mac_cmd.a = dy_q;        mac_cmd.b = ca;  end
          STEP_DZR12: begin mac_cmd.a = dz_q; mac_cmd.b = OpBW'(r12_q); end
          STEP_DXR20: begin mac_cmd.a = dx_q; mac_cmd.b = OpBW'(r20_q); end
          STEP_DYSA:  begin mac_cmd.a = dy_q;        mac_cmd.b = sa;  end
          STEP_DZR22: begin mac_cmd.a = dz_q; mac_cmd.b = OpBW'(r22_q); end
          STEP_XCFU:  begin mac_cmd.a = xc_q;        mac_cmd.b = fu;  end
          STEP_YCFV:  begin mac_cmd.a = yc_q;        mac_cmd.b = fv;  end
          default:    begin mac_cmd.a = '0;          mac_cmd.b = '0;  end
        endcase
        // A new sum starts on the first product of each group.
        mac_cmd.clear = (step_q == STEP_SASB) || (step_q == STEP_SACB)
                     || (step_q == STEP_CASB) || (step_q == STEP_CACB)
                     || (step_q == STEP_DXCB) || (step_q == STEP_DXR10)
                     || (step_q == STEP_DXR20) || (step_q == STEP_XCFU)
                     || (step_q == STEP_YCFV);
      end
      S_MACW: begin
        if (mac_done && step_q == STEP_DZR22 && zc_le0) begin
          res_valid_d  = 1'b1;
          res_status_d = STAT_BEHIND;
        end
      end
      S_DIVU: div_start = 1'b1;
      S_DIVV: begin
        div_start = 1'b1;
        div_num   = nv_q;
      end
      S_PLACE: begin
        if (off_frame) begin
          res_valid_d  = 1'b1;
          res_status_d = STAT_OFF;
        end
      end
      S_WRITE: begin
        ram_we       = 1'b1;
        ram_addr     = waddr_q;
        ram_wdata    = colour_q;
        res_valid_d  = 1'b1;
        res_status_d = STAT_DRAWN;
        res_px_d     = col_full[7:0];
        res_py_d     = row_full[7:0];
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      step_q      <= STEP_SASB;
      ptr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      if (take) begin
        step_q <= STEP_SASB;
        ptr_q  <= '0;
      end else if (state_q == S_CLEAR || state_q == S_FILL) begin
        ptr_q <= ptr_q + 1'b1;
      end else if (state_q == S_MACW && mac_done && step_q != STEP_YCFV) begin
        step_q <= step_e'(4'(step_q) + 4'd1);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_px_q     <= res_px_d;
    res_py_q     <= res_py_d;
    res_col_q    <= res_col_d;
    if (take) begin
      colour_q <= colour_i;
      idx_q    <= AW'(read_index_i);
      rd_ok_q  <= (32'(read_index_i) < 32'(PixelCount));
      // Axis swap: X = x, Y = -z, Z = y, then camera offset.
      dx_q <= OpAW'($signed(point_x_i)) - OpAW'($signed(campx_q));
      dy_q <= -OpAW'($signed(point_z_i)) - OpAW'($signed(campy_q));
      dz_q <= OpAW'($signed(point_y_i)) - OpAW'($signed(campz_q));
    end
    if (state_q == S_MACW && mac_done) begin
      unique case (step_q)
        STEP_SASB:  r10_q <= -18'(acc_sh);
        STEP_SACB:  r12_q <= -18'(acc_sh);
        STEP_CASB:  r20_q <= 18'(acc_sh);
        STEP_CACB:  r22_q <= 18'(acc_sh);
        STEP_DZSB:  xc_q  <= OpAW'(acc_sh);
        STEP_DZR12: yc_q  <= OpAW'(acc_sh);
        STEP_DZR22: zc_q  <= OpAW'(acc_sh);
        STEP_XCFU:  nu_q  <= mac_acc;
        STEP_YCFV:  nv_q  <= mac_acc;
        default:    ;
      endcase
    end
    if (state_q == S_DIVUW && div_done) begin
      u_q <= 65'(div_quot) + $signed({41'b0, du, 8'b0});
    end
    if (state_q == S_DIVVW && div_done) begin
      v_q <= 65'(div_quot) + $signed({41'b0, dv, 8'b0});
    end
    if (state_q == S_PLACE) begin
      waddr_q <= AW'(lin_addr);
    end
  end

  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign pixel_x_o      = res_px_q;
  assign pixel_y_o      = res_py_q;
  assign read_colour_o  = res_col_q;

  ppp_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mac_cmd),
    .done_o (mac_done),
    .acc_o  (mac_acc)
  );

  ppp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (zc_q[DivDW-1:0]),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  ppp_ram #(
    .WIDTH (32),
    .DEPTH (PixelCount)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // A result word is only shown once the block is back to idle.
  `ASSERT_PROP(a_res_idle, clk_i, rst_ni, result_valid_o |-> !busy, "result while busy")
  // Any real operation keeps the block busy on the next cycle.
  `ASSERT_PROP(a_take_busy, clk_i, rst_ni, (start && !busy && opcode_i != OP_NONE) |=> busy, "operation dropped")
  // Coordinates are zero unless a point was drawn.
  `ASSERT_NEVER(a_coord_zero, clk_i, rst_ni, result_valid_o && status_o != STAT_DRAWN && (pixel_x_o != '0 || pixel_y_o != '0), "stray coordinates")

endmodule
